### rtl/assert_macros.svh
// assertion macros for the two stack block
// used by the top level; no other dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
    lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(lbl, clk_s, rstn_s, ante, cons)
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)
`endif

`endif

### rtl/tsm_pkg.sv
// shared types and codes for the two stack block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tsm_pkg;

    localparam int WORD_W  = 32;
    localparam int COUNT_W = 9;

    typedef logic [2:0]         req_t;
    typedef logic [1:0]         status_t;
    typedef logic [WORD_W-1:0]  word_t;
    typedef logic [COUNT_W-1:0] count_t;

    localparam req_t REQ_PUSH_A = 3'd0;
    localparam req_t REQ_PUSH_B = 3'd1;
    localparam req_t REQ_POP_A  = 3'd2;
    localparam req_t REQ_POP_B  = 3'd3;
    localparam req_t REQ_QUERY  = 3'd4;

    localparam status_t ST_DONE      = 2'd0;
    localparam status_t ST_OVERFLOW  = 2'd1;
    localparam status_t ST_UNDERFLOW = 2'd2;

    localparam word_t EMPTY_TOP = {WORD_W{1'b1}};

    typedef struct packed {
        status_t status;
        word_t   top_a;
        word_t   top_b;
        count_t  count_a;
        count_t  count_b;
    } result_t;

    typedef struct packed {
        logic    load;
        result_t data;
    } rsp_load_t;

endpackage

`default_nettype wire

### rtl/tsm_if.sv
// request and response channel interfaces
// depends on tsm_pkg
`timescale 1ns / 1ps
`default_nettype none

interface tsm_req_if import tsm_pkg::*; ();
    logic  valid;
    logic  ready;
    req_t  req_type;
    word_t push_value;

    modport source (output valid, output req_type, output push_value, input ready);
    modport sink   (input valid, input req_type, input push_value, output ready);
endinterface

interface tsm_rsp_if import tsm_pkg::*; ();
    logic    valid;
    logic    ready;
    status_t status;
    word_t   top_a;
    word_t   top_b;
    count_t  count_a;
    count_t  count_b;

    modport source (output valid, output status, output top_a, output top_b,
                    output count_a, output count_b, input ready);
    modport sink   (input valid, input status, input top_a, input top_b,
                    input count_a, input count_b, output ready);
endinterface

`default_nettype wire

### rtl/tsm_ram.sv
// generic single write port ram with registered read
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

module tsm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             wr_en,
    input  wire logic [AW-1:0]    wr_addr,
    input  wire logic [WIDTH-1:0] wr_data,
    input  wire logic             rd_en,
    input  wire logic [AW-1:0]    rd_addr,
    output logic      [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

### rtl/tsm_ctrl.sv
// stack pointers, cached top words and word memory access sequencing
// depends on tsm_pkg and tsm_if
`timescale 1ns / 1ps
`default_nettype none

module tsm_ctrl import tsm_pkg::*; #(
    parameter int CAPACITY = 256,
    localparam int DW      = $clog2(CAPACITY + 1),
    localparam int AW      = $clog2(CAPACITY)
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    tsm_req_if.sink         req,
    input  wire logic       slot_ready,
    output rsp_load_t       rsp_load,
    output logic [DW-1:0]   depth_a,
    output logic [DW-1:0]   depth_b,
    output logic            mem_wr_en,
    output logic [AW-1:0]   mem_wr_addr,
    output word_t           mem_wr_data,
    output logic            mem_rd_en,
    output logic [AW-1:0]   mem_rd_addr,
    input  wire word_t      mem_rd_data
);

    localparam logic S_IDLE  = 1'b0;
    localparam logic S_FETCH = 1'b1;
    localparam logic SEL_A   = 1'b0;
    localparam logic SEL_B   = 1'b1;

    localparam int EW = (DW > COUNT_W) ? DW : COUNT_W;
    localparam logic [DW-1:0] CAP_M1 = DW'(CAPACITY - 1);
    localparam logic [DW:0]   CAP_X  = (DW + 1)'(CAPACITY);

    logic          state_reg, state_next;
    logic          sel_reg, sel_next;
    logic [DW-1:0] da_reg, da_next;
    logic [DW-1:0] db_reg, db_next;
    word_t         ta_reg, ta_next;
    word_t         tb_reg, tb_next;

    logic          accept;
    logic          full;
    logic          load_en;
    status_t       status;
    logic [EW-1:0] ca_ext;
    logic [EW-1:0] cb_ext;
    word_t         top_a_out;
    word_t         top_b_out;

    assign req.ready = (state_reg == S_IDLE) && slot_ready;
    assign accept    = req.valid && req.ready;
    assign full      = ({1'b0, da_reg} + {1'b0, db_reg}) >= CAP_X;

    always_comb
    begin
        state_next  = state_reg;
        sel_next    = sel_reg;
        da_next     = da_reg;
        db_next     = db_reg;
        ta_next     = ta_reg;
        tb_next     = tb_reg;
        status      = ST_DONE;
        load_en     = 1'b0;
        mem_wr_en   = 1'b0;
        mem_wr_addr = '0;
        mem_wr_data = req.push_value;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;

        if (state_reg == S_FETCH)
        begin
            if (sel_reg == SEL_A)
            begin
                ta_next = mem_rd_data;
            end
            else
            begin
                tb_next = mem_rd_data;
            end
            state_next = S_IDLE;
            load_en    = 1'b1;
        end
        else if (accept)
        begin
            load_en = 1'b1;
            unique case (req.req_type)
                REQ_PUSH_A:
                begin
                    if (full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(da_reg);
                        da_next     = da_reg + DW'(1);
                        ta_next     = req.push_value;
                    end
                end
                REQ_PUSH_B:
                begin
                    if (full)
                    begin
                        status = ST_OVERFLOW;
                    end
                    else
                    begin
                        mem_wr_en   = 1'b1;
                        mem_wr_addr = AW'(CAP_M1 - db_reg);
                        db_next     = db_reg + DW'(1);
                        tb_next     = req.push_value;
                    end
                end
                REQ_POP_A:
                begin
                    if (da_reg == '0)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        da_next = da_reg - DW'(1);
                        if (da_reg > DW'(1))
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = AW'(da_reg - DW'(2));
                            sel_next    = SEL_A;
                            state_next  = S_FETCH;
                            load_en     = 1'b0;
                        end
                    end
                end
                REQ_POP_B:
                begin
                    if (db_reg == '0)
                    begin
                        status = ST_UNDERFLOW;
                    end
                    else
                    begin
                        db_next = db_reg - DW'(1);
                        if (db_reg > DW'(1))
                        begin
                            mem_rd_en   = 1'b1;
                            mem_rd_addr = AW'(CAP_M1 - (db_reg - DW'(2)));
                            sel_next    = SEL_B;
                            state_next  = S_FETCH;
                            load_en     = 1'b0;
                        end
                    end
                end
                default:
                begin
                    status = ST_DONE;
                end
            endcase
        end
    end

    assign ca_ext    = EW'(da_next);
    assign cb_ext    = EW'(db_next);
    assign top_a_out = (da_next == '0) ? EMPTY_TOP : ta_next;
    assign top_b_out = (db_next == '0) ? EMPTY_TOP : tb_next;

    assign rsp_load = {load_en, status, top_a_out, top_b_out,
                       ca_ext[COUNT_W-1:0], cb_ext[COUNT_W-1:0]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= SEL_A;
            da_reg    <= '0;
            db_reg    <= '0;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            da_reg    <= da_next;
            db_reg    <= db_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ta_reg <= ta_next;
        tb_reg <= tb_next;
    end

    assign depth_a = da_reg;
    assign depth_b = db_reg;

endmodule

`default_nettype wire

### rtl/tsm_out.sv
// response output register
// depends on tsm_pkg and tsm_if
`timescale 1ns / 1ps
`default_nettype none

module tsm_out import tsm_pkg::*; (
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire rsp_load_t rsp_load,
    output logic           slot_ready,
    tsm_rsp_if.source      rsp
);

    logic    valid_reg, valid_next;
    result_t data_reg;

    assign slot_ready = !valid_reg || rsp.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (rsp_load.load)
        begin
            valid_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rsp_load.load)
        begin
            data_reg <= rsp_load.data;
        end
    end

    assign rsp.valid   = valid_reg;
    assign rsp.status  = data_reg.status;
    assign rsp.top_a   = data_reg.top_a;
    assign rsp.top_b   = data_reg.top_b;
    assign rsp.count_a = data_reg.count_a;
    assign rsp.count_b = data_reg.count_b;

endmodule

`default_nettype wire

### rtl/two_stacks_shared_memory_top.sv
// response: registered in tsm_out; a pop that leaves one or more words first waits in the fetch state
// throughput: one transaction per cycle while the response slot is free; such a pop holds the block
// in the fetch state while the single read port of the word memory fetches the new top word
// reset: both counts cleared, word memory left as is with no clearing pass
// depends on tsm_pkg, tsm_if, tsm_ram, tsm_ctrl, tsm_out and assert_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module two_stacks_shared_memory_top import tsm_pkg::*; #(
    parameter int CAPACITY = 256
) (
    input  wire logic clk,
    input  wire logic rst_n,
    tsm_req_if.sink   req,
    tsm_rsp_if.source rsp
);

    localparam int DW = $clog2(CAPACITY + 1);
    localparam int AW = $clog2(CAPACITY);

    rsp_load_t       rsp_load;
    logic            slot_ready;
    logic [DW-1:0]   depth_a;
    logic [DW-1:0]   depth_b;
    logic [DW:0]     depth_sum;
    logic            mem_wr_en;
    logic [AW-1:0]   mem_wr_addr;
    word_t           mem_wr_data;
    logic            mem_rd_en;
    logic [AW-1:0]   mem_rd_addr;
    word_t           mem_rd_data;

    tsm_ctrl #(
        .CAPACITY (CAPACITY)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .slot_ready  (slot_ready),
        .rsp_load    (rsp_load),
        .depth_a     (depth_a),
        .depth_b     (depth_b),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    tsm_ram #(
        .WIDTH (WORD_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    tsm_out u_out (
        .clk        (clk),
        .rst_n      (rst_n),
        .rsp_load   (rsp_load),
        .slot_ready (slot_ready),
        .rsp        (rsp)
    );

    assign depth_sum = {1'b0, depth_a} + {1'b0, depth_b};

    `ASSERT_IMPLIES(a_depth_bound, clk, rst_n, 1'b1, depth_sum <= (DW + 1)'(CAPACITY))
    `ASSERT_IMPLIES(a_accept_slot_free, clk, rst_n, req.valid && req.ready, !rsp.valid || rsp.ready)
    `ASSERT_NEXT(a_load_shows, clk, rst_n, rsp_load.load, rsp.valid)
    `ASSERT_IMPLIES(a_no_rw_overlap, clk, rst_n, mem_rd_en, !mem_wr_en)

endmodule

`default_nettype wire
